// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Width of one stored value and of the reported count
	localparam int DATA_W      = 32;
	localparam int CNT_OUT_W   = 5;

	// Default number of cells in the chain
	localparam int DEF_CAPACITY = 16;

	// Value returned by an extract on an empty queue
	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;   // insert the broadcast item
		logic ext;   // shift toward the head
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a value, compares it to the broadcast
// item and takes its own, the item, or a neighbor's value.
// ----------------------------------------------------------------------------
module spq_cell (
	input  wire                                    clk,
	input  spq_pkg::cell_ctrl_t                    ctrl,
	input  wire logic signed [spq_pkg::DATA_W-1:0] item,
	input  wire                                    occupied,
	input  wire                                    prev_stay,
	input  wire logic signed [spq_pkg::DATA_W-1:0] prev_val,
	input  wire logic signed [spq_pkg::DATA_W-1:0] next_val,
	output logic                                   stay,
	output logic signed [spq_pkg::DATA_W-1:0]      val
);

	logic signed [spq_pkg::DATA_W-1:0] val_q;
	logic signed [spq_pkg::DATA_W-1:0] ins_val;

	// Keep the slot when it holds a value no smaller than the item
	assign stay = occupied && (val_q >= item);

	// Pick the insert value: own, the new item at the boundary, or shift down
	always_comb begin
		priority if (stay) begin
			ins_val = val_q;
		end else if (prev_stay) begin
			ins_val = item;
		end else begin
			ins_val = prev_val;
		end
	end

	// Hold, insert or advance toward the head
	always_ff @(posedge clk) begin
		priority if (ctrl.ins) begin
			val_q <= ins_val;
		end else if (ctrl.ext) begin
			val_q <= next_val;
		end
	end

	assign val = val_q;

endmodule
`default_nettype wire

// ===== design/sorted_priority_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Max-priority queue held as a descending chain of compare-and-shift cells.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid, in_ready, req_type, value  | into core
//   out     | out_valid, out_ready, max_value,     | out of core
//           | status, is_empty, count              |
//
// One word is taken per cycle while the output register is free or draining;
// its result appears in the output register on the next cycle. All cells
// compare against the item in parallel and shift in the same edge.
// A new word is taken while a result waits, as long as that result leaves.
// Reset clears occupancy and out_valid only; cells are undefined until written.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
	parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire                                    req_type,
	input  wire logic signed [spq_pkg::DATA_W-1:0] value,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic signed [spq_pkg::DATA_W-1:0]      max_value,
	output logic [1:0]                             status,
	output logic                                   is_empty,
	output logic [spq_pkg::CNT_OUT_W-1:0]          count
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]                      cnt_q;
	logic [CW-1:0]                      cnt_next;
	logic                               accept;
	logic                               full;
	logic                               empty;
	spq_pkg::cell_ctrl_t                ctrl;
	logic [CAPACITY-1:0]                stay;
	logic signed [spq_pkg::DATA_W-1:0]  cell_val [CAPACITY];

	logic                               out_valid_q;
	logic signed [spq_pkg::DATA_W-1:0]  max_value_q;
	spq_pkg::status_t                   status_q;
	logic                               is_empty_q;
	logic [CW-1:0]                      cnt_out_q;
	logic signed [spq_pkg::DATA_W-1:0]  max_next;
	spq_pkg::status_t                   status_next;
	logic [CW+spq_pkg::CNT_OUT_W-1:0]   cnt_wide;

	// Take a word whenever the output register is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (cnt_q == CW'(CAPACITY));
	assign empty    = (cnt_q == '0);

	assign ctrl.ins = accept && !req_type && !full;
	assign ctrl.ext = accept && req_type && !empty;

	// Build the chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic                              prev_stay;
		logic signed [spq_pkg::DATA_W-1:0] prev_val;
		logic signed [spq_pkg::DATA_W-1:0] next_val;

		if (i == 0) begin : g_head
			assign prev_stay = 1'b1;
			assign prev_val  = value;
		end else begin : g_body
			assign prev_stay = stay[i-1];
			assign prev_val  = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_val = cell_val[i];
		end else begin : g_inner
			assign next_val = cell_val[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.item      (value),
			.occupied  (IDX < cnt_q),
			.prev_stay (prev_stay),
			.prev_val  (prev_val),
			.next_val  (next_val),
			.stay      (stay[i]),
			.val       (cell_val[i])
		);
	end

	// Form the result of the accepted word
	always_comb begin
		cnt_next    = cnt_q;
		max_next    = '0;
		status_next = spq_pkg::ST_OK;
		priority if (!req_type && full) begin
			status_next = spq_pkg::ST_FULL;
		end else if (!req_type) begin
			cnt_next = cnt_q + CW'(1);
		end else if (empty) begin
			max_next    = spq_pkg::EMPTY_VALUE;
			status_next = spq_pkg::ST_EMPTY;
		end else begin
			max_next = cell_val[0];
			cnt_next = cnt_q - CW'(1);
		end
	end

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_next;
		end
	end

	// Hold the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			max_value_q <= max_next;
			status_q    <= status_next;
			is_empty_q  <= (cnt_next == '0);
			cnt_out_q   <= cnt_next;
		end
	end

	// Report count modulo the output width
	assign cnt_wide  = {{spq_pkg::CNT_OUT_W{1'b0}}, cnt_out_q};
	assign out_valid = out_valid_q;
	assign max_value = max_value_q;
	assign status    = status_q;
	assign is_empty  = is_empty_q;
	assign count     = cnt_wide[spq_pkg::CNT_OUT_W-1:0];

	// Occupancy never passes the number of cells
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("occupancy above capacity");

	// The two head cells stay in descending order
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CW'(2)) |-> (cell_val[0] >= cell_val[1]))
		else $error("head cells out of order");

	// A successful extract drops occupancy by one
	a_ext_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ext |=> (cnt_q == $past(cnt_q) - CW'(1)))
		else $error("extract did not shrink occupancy");

	// An empty-extract result reports the sentinel and an empty queue
	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == spq_pkg::ST_EMPTY) |->
		(is_empty_q && max_value_q == spq_pkg::EMPTY_VALUE))
		else $error("empty extract result malformed");

	// A rejected insert leaves the queue full
	a_full_res: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == spq_pkg::ST_FULL) |->
		(cnt_out_q == CW'(CAPACITY) && max_value_q == '0))
		else $error("full reject result malformed");

endmodule
`default_nettype wire
